### src/msd_pkg.sv
`timescale 1ns / 1ps

package msd_pkg;

    // Deframer phases
    localparam logic [1:0] PH_MAGIC   = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    // Request kinds on the input channel
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Result event codes
    localparam logic [2:0] EV_OK       = 3'd0;
    localparam logic [2:0] EV_DEVINFO  = 3'd1;
    localparam logic [2:0] EV_MEMREAD  = 3'd2;
    localparam logic [2:0] EV_BAD_LEN  = 3'd3;
    localparam logic [2:0] EV_SHORT    = 3'd4;
    localparam logic [2:0] EV_TOO_LONG = 3'd5;
    localparam logic [2:0] EV_UNKNOWN  = 3'd6;

    // Packet types
    localparam logic [7:0] TYPE_DEVINFO = 8'h01;
    localparam logic [7:0] TYPE_MEMREAD = 8'h02;

    localparam logic [31:0] SYNC_WORD = 32'hDEAD_BEEF;

    // Configuration register indexes and reset values
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_BUFSIZE = 1'b1;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [15:0] BUFSIZE_RESET = 16'd5000;

    // Smallest payload that carries address and length
    localparam logic [15:0] MIN_READ_PAYLOAD = 16'd8;

    // One output record: a single result, or an "ok" beat followed by a dispatch
    typedef struct packed {
        logic        pair;
        logic [2:0]  ev;
        logic [7:0]  ptype;
        logic [31:0] addr;
        logic [15:0] len;
    } result_t;

endpackage

### src/magic_sync_packet_deframer_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_cmd, s_rx_byte
// m_        out        m_valid / m_ready   m_event_res, m_packet_type, m_read_address,
//                                          m_read_length, m_last
// cfg_      in         cfg_we (no wait)    cfg_index, cfg_wdata
//
// One request per cycle enters the input register while s_ready is high and is deframed
// in a single pass into the result register. A request that completes a packet yields
// two result beats (ok, then dispatch), so the next productive request waits in the
// input register until the dispatch beat is taken. Requests that yield nothing never
// wait on the result side. Reset (aresetn, synchronous) clears the frame state and
// loads timeout 100 and buffer size 5000. A stalled m_ready backs up into s_ready.
module magic_sync_packet_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_rx_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [7:0]  m_packet_type,
    output logic [31:0] m_read_address,
    output logic [15:0] m_read_length,
    output logic        m_last,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic [15:0] timeout_reg;
    logic [15:0] bufsize_reg;

    logic        in_vld_reg;
    logic        in_cmd_reg;
    logic [7:0]  in_byte_reg;

    logic             has_result;
    logic             can_load;
    logic             advance;
    msd_pkg::result_t result;

    // Configuration registers: plain writes, no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= msd_pkg::TIMEOUT_RESET;
            bufsize_reg <= msd_pkg::BUFSIZE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                msd_pkg::CFG_TIMEOUT: timeout_reg <= cfg_wdata;
                msd_pkg::CFG_BUFSIZE: bufsize_reg <= cfg_wdata;
            endcase
        end
    end

    // Advance the held request unless its results have nowhere to go
    assign advance = in_vld_reg && (!has_result || can_load);
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg  <= s_cmd;
            in_byte_reg <= s_rx_byte;
        end
    end

    msd_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .cmd         (in_cmd_reg),
        .rx_byte     (in_byte_reg),
        .timeout_ms  (timeout_reg),
        .buffer_size (bufsize_reg),
        .has_result  (has_result),
        .result      (result)
    );

    msd_out u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (advance && has_result),
        .rec            (result),
        .can_load       (can_load),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_packet_type  (m_packet_type),
        .m_read_address (m_read_address),
        .m_read_length  (m_read_length),
        .m_last         (m_last)
    );

endmodule

### src/msd_core.sv
`timescale 1ns / 1ps

module msd_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic             cmd,
    input  logic [7:0]       rx_byte,
    input  logic [15:0]      timeout_ms,
    input  logic [15:0]      buffer_size,
    output logic             has_result,
    output msd_pkg::result_t result
);

    logic [1:0]  phase_reg,   phase_next;
    logic [15:0] pos_reg,     pos_next;
    logic [31:0] shift_reg,   shift_next;
    logic [7:0]  ftype_reg,   ftype_next;
    logic [15:0] plen_reg,    plen_next;
    logic [31:0] raddr_reg,   raddr_next;
    logic [31:0] rlen_reg,    rlen_next;
    logic [15:0] idle_reg,    idle_next;

    logic [15:0] idle_inc;
    logic [15:0] pos_inc;
    logic        finish;
    logic [16:0] rounded;
    logic [15:0] rd_len;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        shift_next = shift_reg;
        ftype_next = ftype_reg;
        plen_next  = plen_reg;
        raddr_next = raddr_reg;
        rlen_next  = rlen_reg;
        idle_next  = idle_reg;
        finish     = 1'b0;
        has_result = 1'b0;
        result     = '0;
        idle_inc   = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
        pos_inc    = pos_reg + 16'd1;
        rounded    = '0;
        rd_len     = '0;

        if (cmd == msd_pkg::CMD_TICK) begin
            if (idle_inc > timeout_ms) begin
                phase_next = msd_pkg::PH_MAGIC;
                pos_next   = '0;
                idle_next  = '0;
            end else begin
                idle_next = idle_inc;
            end
        end else begin
            idle_next = '0;
            unique case (phase_reg)
                msd_pkg::PH_HEADER: begin
                    unique case (pos_reg[1:0])
                        2'd0:    ftype_next = rx_byte;
                        2'd1:    plen_next  = {rx_byte, 8'h00};
                        default: plen_next  = {plen_reg[15:8], rx_byte};
                    endcase
                    if (pos_reg[1:0] == 2'd2) begin
                        pos_next = '0;
                        if (plen_next > buffer_size) begin
                            has_result   = 1'b1;
                            result.ev    = msd_pkg::EV_BAD_LEN;
                            result.ptype = ftype_reg;
                            phase_next   = msd_pkg::PH_MAGIC;
                        end else begin
                            raddr_next = '0;
                            rlen_next  = '0;
                            if (plen_next == 16'd0) begin
                                finish = 1'b1;
                            end else begin
                                phase_next = msd_pkg::PH_PAYLOAD;
                            end
                        end
                    end else begin
                        pos_next = pos_inc;
                    end
                end
                msd_pkg::PH_PAYLOAD: begin
                    // Keep only the first eight payload bytes, little-endian
                    if (pos_reg < 16'd4) begin
                        raddr_next[pos_reg[1:0]*8 +: 8] = rx_byte;
                    end else if (pos_reg < 16'd8) begin
                        rlen_next[pos_reg[1:0]*8 +: 8] = rx_byte;
                    end
                    pos_next = pos_inc;
                    if (pos_inc >= plen_reg) begin
                        finish = 1'b1;
                    end
                end
                default: begin
                    phase_next = msd_pkg::PH_MAGIC;
                    shift_next = {shift_reg[23:0], rx_byte};
                    pos_next   = {14'd0, pos_reg[1:0]} + 16'd1;
                    if (pos_reg[1:0] == 2'd3) begin
                        pos_next = '0;
                        if (shift_next == msd_pkg::SYNC_WORD) begin
                            phase_next = msd_pkg::PH_HEADER;
                        end
                    end
                end
            endcase
        end

        if (finish) begin
            phase_next   = msd_pkg::PH_MAGIC;
            pos_next     = '0;
            has_result   = 1'b1;
            result.pair  = 1'b1;
            result.ptype = ftype_next;
            if (ftype_next == msd_pkg::TYPE_DEVINFO) begin
                result.ev = msd_pkg::EV_DEVINFO;
            end else if (ftype_next == msd_pkg::TYPE_MEMREAD) begin
                if (plen_next < msd_pkg::MIN_READ_PAYLOAD) begin
                    result.ev = msd_pkg::EV_SHORT;
                end else if (rlen_next >= {16'd0, buffer_size}) begin
                    result.ev = msd_pkg::EV_TOO_LONG;
                end else begin
                    // Round up to a word multiple, clip to the buffer size
                    rounded = ({1'b0, rlen_next[15:0]} + 17'd3) & ~17'd3;
                    rd_len  = (rounded > {1'b0, buffer_size}) ? buffer_size : rounded[15:0];
                    result.ev   = msd_pkg::EV_MEMREAD;
                    result.addr = raddr_next;
                    result.len  = rd_len;
                end
            end else begin
                result.ev = msd_pkg::EV_UNKNOWN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= msd_pkg::PH_MAGIC;
            pos_reg   <= '0;
            shift_reg <= '0;
            ftype_reg <= '0;
            plen_reg  <= '0;
            raddr_reg <= '0;
            rlen_reg  <= '0;
            idle_reg  <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            shift_reg <= shift_next;
            ftype_reg <= ftype_next;
            plen_reg  <= plen_next;
            raddr_reg <= raddr_next;
            rlen_reg  <= rlen_next;
            idle_reg  <= idle_next;
        end
    end

endmodule

### src/msd_out.sv
`timescale 1ns / 1ps

module msd_out (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  msd_pkg::result_t rec,
    output logic             can_load,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_event_res,
    output logic [7:0]       m_packet_type,
    output logic [31:0]      m_read_address,
    output logic [15:0]      m_read_length,
    output logic             m_last
);

    msd_pkg::result_t rec_reg;
    logic             vld_reg;
    logic             first_reg;

    // Free once the final beat of the held record goes out
    assign can_load = !vld_reg || (m_ready && !first_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= 1'b0;
            first_reg <= 1'b0;
        end else if (load) begin
            vld_reg   <= 1'b1;
            first_reg <= rec.pair;
        end else if (vld_reg && m_ready) begin
            if (first_reg) begin
                first_reg <= 1'b0;
            end else begin
                vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rec_reg <= rec;
        end
    end

    assign m_valid        = vld_reg;
    assign m_event_res    = first_reg ? msd_pkg::EV_OK : rec_reg.ev;
    assign m_packet_type  = rec_reg.ptype;
    assign m_read_address = first_reg ? 32'd0 : rec_reg.addr;
    assign m_read_length  = first_reg ? 16'd0 : rec_reg.len;
    assign m_last         = !first_reg;

endmodule

### test/tb_magic_sync_packet_deframer_top.sv
`timescale 1ns / 1ps

module tb_magic_sync_packet_deframer_top;

    localparam int HOLD_CYCLES    = 800;   // long receiver hold-off to back the block up
    localparam int STALL_LIMIT    = 5000;  // cycles with no handshake before giving up
    localparam int SETTLE_CYCLES  = 12;    // let a trailing request clear the pipeline
    localparam int NUM_PHASES     = 6;
    localparam int PRESSURE_PHASE = 2;
    localparam int NUM_DIRECTED   = 26;

    // One result beat as it appears on the m_ channel
    typedef struct packed {
        logic [2:0]  ev;
        logic [7:0]  ptype;
        logic [31:0] addr;
        logic [15:0] len;
        logic        last;
    } frame_res_t;

    // One directed request; typed rows carry their own expected outcome
    typedef struct packed {
        logic       cmd;
        logic [7:0] b;
        logic       typed;
        logic [1:0] nres;
        logic [2:0] ev;
        logic [7:0] ptype;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_cmd;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_event_res;
    logic [7:0]  m_packet_type;
    logic [31:0] m_read_address;
    logic [15:0] m_read_length;
    logic        m_last;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    // Deframer shadow state, kept in step with every accepted request
    logic [1:0]  fr_phase;
    logic [15:0] fr_pos;
    logic [31:0] fr_shift;
    logic [7:0]  fr_type;
    logic [15:0] fr_plen;
    logic [31:0] fr_addr;
    logic [31:0] fr_rlen;
    logic [15:0] fr_idle;
    logic [15:0] cfg_timeout;
    logic [15:0] cfg_bufsize;

    frame_res_t  step_res [2];
    frame_res_t  expected_q [$];
    frame_res_t  want;
    stim_row_t   directed_rows [NUM_DIRECTED];

    int errors = 0;
    int items_sent = 0;
    int stall_cycles;
    int rx_gap;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    bit hold_request = 1'b0;

    // Register settings per random phase: reset values, both extremes, buffer sizes off a
    // word multiple that force the read length clip, and short timeouts that abandon frames
    logic [15:0] phase_timeout [NUM_PHASES] = '{16'd100, 16'd0, 16'd65535, 16'd3, 16'd20, 16'd15};
    logic [15:0] phase_bufsize [NUM_PHASES] = '{16'd5000, 16'd8, 16'd65532, 16'd42, 16'd1002,
                                                16'd8};
    int          phase_items   [NUM_PHASES] = '{300, 300, 300, 350, 350, 300};

    magic_sync_packet_deframer_top uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_packet_type  (m_packet_type),
        .m_read_address (m_read_address),
        .m_read_length  (m_read_length),
        .m_last         (m_last),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Close a packet: an ok beat, then the dispatch beat for its type
    function automatic int packet_done();
        logic [32:0] rounded;
        step_res[0] = {msd_pkg::EV_OK, fr_type, 32'd0, 16'd0, 1'b0};
        if (fr_type == msd_pkg::TYPE_DEVINFO) begin
            step_res[1] = {msd_pkg::EV_DEVINFO, fr_type, 32'd0, 16'd0, 1'b1};
        end else if (fr_type == msd_pkg::TYPE_MEMREAD) begin
            if (fr_plen < msd_pkg::MIN_READ_PAYLOAD) begin
                step_res[1] = {msd_pkg::EV_SHORT, fr_type, 32'd0, 16'd0, 1'b1};
            end else if (fr_rlen >= {16'd0, cfg_bufsize}) begin
                step_res[1] = {msd_pkg::EV_TOO_LONG, fr_type, 32'd0, 16'd0, 1'b1};
            end else begin
                // round up to a word, then clip to the buffer
                rounded = ({1'b0, fr_rlen} + 33'd3) & ~33'd3;
                if (rounded > {17'd0, cfg_bufsize})
                    rounded = {17'd0, cfg_bufsize};
                step_res[1] = {msd_pkg::EV_MEMREAD, fr_type, fr_addr, rounded[15:0], 1'b1};
            end
        end else begin
            step_res[1] = {msd_pkg::EV_UNKNOWN, fr_type, 32'd0, 16'd0, 1'b1};
        end
        fr_phase = msd_pkg::PH_MAGIC;
        fr_pos = 16'd0;
        return 2;
    endfunction

    // Advance the shadow deframer by one request; fill step_res and return the count
    function automatic int deframe_step(input logic cmd, input logic [7:0] b);
        if (cmd == msd_pkg::CMD_TICK) begin
            if (fr_idle != 16'hFFFF)
                fr_idle = fr_idle + 16'd1;
            if (fr_idle > cfg_timeout) begin
                // abandon whatever frame is in progress
                fr_phase = msd_pkg::PH_MAGIC;
                fr_pos = 16'd0;
                fr_idle = 16'd0;
            end
            return 0;
        end
        fr_idle = 16'd0;
        case (fr_phase)
            msd_pkg::PH_HEADER: begin
                if (fr_pos == 16'd0)
                    fr_type = b;
                else if (fr_pos == 16'd1)
                    fr_plen = {b, 8'h00};
                else
                    fr_plen = {fr_plen[15:8], b};
                fr_pos = fr_pos + 16'd1;
                if (fr_pos < 16'd3)
                    return 0;
                fr_pos = 16'd0;
                if (fr_plen > cfg_bufsize) begin
                    step_res[0] = {msd_pkg::EV_BAD_LEN, fr_type, 32'd0, 16'd0, 1'b1};
                    fr_phase = msd_pkg::PH_MAGIC;
                    return 1;
                end
                fr_addr = 32'd0;
                fr_rlen = 32'd0;
                if (fr_plen == 16'd0)
                    return packet_done();
                fr_phase = msd_pkg::PH_PAYLOAD;
                return 0;
            end
            msd_pkg::PH_PAYLOAD: begin
                // first eight payload bytes: little-endian address, then length
                if (fr_pos < 16'd4)
                    fr_addr = fr_addr | ({24'd0, b} << (8 * fr_pos));
                else if (fr_pos < 16'd8)
                    fr_rlen = fr_rlen | ({24'd0, b} << (8 * (fr_pos - 16'd4)));
                fr_pos = fr_pos + 16'd1;
                if (fr_pos >= fr_plen)
                    return packet_done();
                return 0;
            end
            default: begin
                // magic hunt: whole four-byte blocks, no sliding
                fr_phase = msd_pkg::PH_MAGIC;
                fr_shift = {fr_shift[23:0], b};
                fr_pos = {14'd0, fr_pos[1:0]} + 16'd1;
                if (fr_pos < 16'd4)
                    return 0;
                fr_pos = 16'd0;
                if (fr_shift == msd_pkg::SYNC_WORD)
                    fr_phase = msd_pkg::PH_HEADER;
                return 0;
            end
        endcase
    endfunction

    // Offer one request after a random gap, hold it until accepted, then queue what it
    // should produce. Enter and leave at a falling edge.
    task automatic send_request(input logic cmd, input logic [7:0] b, input logic typed,
                                input logic [1:0] tn, input logic [2:0] tev,
                                input logic [7:0] tptype);
        int gap;
        int n;
        frame_res_t r;
        if ($urandom_range(0, 39) == 0)
            tx_calm = ~tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_cmd     <= cmd;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n = deframe_step(cmd, b);
        if (typed) begin
            // directed rows: the outcome is written in the table
            if (tn == 2'd1) begin
                r = {tev, tptype, 32'd0, 16'd0, 1'b1};
                expected_q.push_back(r);
            end else if (tn == 2'd2) begin
                r = {msd_pkg::EV_OK, tptype, 32'd0, 16'd0, 1'b0};
                expected_q.push_back(r);
                r = {tev, tptype, 32'd0, 16'd0, 1'b1};
                expected_q.push_back(r);
            end
        end else begin
            for (int i = 0; i < n; i++)
                expected_q.push_back(step_res[i]);
        end
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic feed(input logic cmd, input logic [7:0] b);
        send_request(cmd, b, 1'b0, 2'd0, msd_pkg::EV_OK, 8'h00);
    endtask

    // Drop valid, wait for every queued result, then let the pipeline settle
    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Mostly well-formed frames with random content; some corrupt magic, some cut short,
    // ticks sprinkled in, and bursts that land right at the timeout boundary
    task automatic random_frame();
        logic [7:0]  ftype;
        logic [15:0] plen;
        logic [31:0] addr;
        logic [31:0] rlen;
        logic [7:0]  b;
        int          total;
        int          sel;
        int          p;
        sel = $urandom_range(0, 9);
        ftype = (sel < 4) ? msd_pkg::TYPE_MEMREAD :
                (sel < 7) ? msd_pkg::TYPE_DEVINFO : 8'($urandom);
        sel = $urandom_range(0, 19);
        if (sel < 14)
            plen = 16'($urandom_range(0, 12));
        else if (sel < 16)
            plen = msd_pkg::MIN_READ_PAYLOAD;
        else if (sel == 16)
            plen = (cfg_bufsize <= 16'd64) ? cfg_bufsize : 16'($urandom_range(0, 12));
        else if (sel == 17)
            plen = cfg_bufsize + 16'd1;
        else if (sel == 18)
            plen = 16'hFFFF;
        else
            plen = 16'($urandom_range(cfg_bufsize + 1, 65535));
        addr = $urandom;
        case ($urandom_range(0, 7))
            0: rlen = 32'd0;
            1: rlen = {16'd0, cfg_bufsize} - 32'd1;
            2: rlen = {16'd0, cfg_bufsize};
            3: rlen = {16'd0, cfg_bufsize} - 32'($urandom_range(2, 4));
            4: rlen = $urandom;
            5: rlen = $urandom_range(0, cfg_bufsize);
            6: rlen = 32'hFFFF_FFFF;
            default: rlen = {16'd0, cfg_bufsize} + 32'($urandom_range(1, 3));
        endcase
        // skip the payload of an oversize frame, the block is back hunting by then
        total = 7 + ((plen <= cfg_bufsize) ? int'(plen) : 0);
        if ($urandom_range(0, 14) == 0)
            total = $urandom_range(1, total - 1);
        for (int k = 0; k < total; k++) begin
            if (k < 4) begin
                b = msd_pkg::SYNC_WORD[31 - 8 * k -: 8];
                if ($urandom_range(0, 24) == 0)
                    b = 8'($urandom);
            end else if (k == 4) begin
                b = ftype;
            end else if (k == 5) begin
                b = plen[15:8];
            end else if (k == 6) begin
                b = plen[7:0];
            end else begin
                p = k - 7;
                if (p < 4)
                    b = addr[8 * p +: 8];
                else if (p < 8)
                    b = rlen[8 * (p - 4) +: 8];
                else
                    b = 8'($urandom);
            end
            feed(msd_pkg::CMD_BYTE, b);
            sel = $urandom_range(0, 31);
            if (sel >= 28) begin
                feed(msd_pkg::CMD_TICK, 8'($urandom));
            end else if (sel == 27 && (cfg_timeout <= 16'd30 || $urandom_range(0, 7) == 0)) begin
                if (cfg_timeout <= 16'd120)
                    repeat (int'(cfg_timeout) + $urandom_range(0, 1))
                        feed(msd_pkg::CMD_TICK, 8'($urandom));
            end
        end
    endtask

    // Line noise: loose bytes and ticks
    task automatic line_noise();
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 3) == 0)
                feed(msd_pkg::CMD_TICK, 8'($urandom));
            else
                feed(msd_pkg::CMD_BYTE, 8'($urandom));
        end
    endtask

    // Receiver: random back-pressure per result, one long hold-off when asked
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_request) begin
                // hold off long enough for the block to fill and stall s_ready
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end
            if ($urandom_range(0, 39) == 0)
                rx_calm = ~rx_calm;
            rx_gap = rx_calm ? 0 : $urandom_range(0, 18);
            if (rx_gap > 0) begin
                m_ready <= 1'b0;
                repeat (rx_gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Compare every accepted result with the oldest expectation, field by field
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: expected no result, actual event %0d type %h addr %h len %0d last %0d",
                         $time, m_event_res, m_packet_type, m_read_address, m_read_length,
                         m_last);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (m_event_res !== want.ev) begin
                    $display("%0t: event_res expected %0d, actual %0d",
                             $time, want.ev, m_event_res);
                    errors++;
                end
                if (m_packet_type !== want.ptype) begin
                    $display("%0t: packet_type expected %h, actual %h",
                             $time, want.ptype, m_packet_type);
                    errors++;
                end
                if (m_read_address !== want.addr) begin
                    $display("%0t: read_address expected %h, actual %h",
                             $time, want.addr, m_read_address);
                    errors++;
                end
                if (m_read_length !== want.len) begin
                    $display("%0t: read_length expected %0d, actual %0d",
                             $time, want.len, m_read_length);
                    errors++;
                end
                if (m_last !== want.last) begin
                    $display("%0t: last expected %0d, actual %0d",
                             $time, want.last, m_last);
                    errors++;
                end
            end
        end
    end

    // Watchdog: give up when neither channel moves for too long
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_cmd     = msd_pkg::CMD_BYTE;
        s_rx_byte = 8'h00;
        cfg_we    = 1'b0;
        cfg_index = msd_pkg::CFG_TIMEOUT;
        cfg_wdata = 16'd0;

        // Shadow state after reset
        fr_phase    = msd_pkg::PH_MAGIC;
        fr_pos      = 16'd0;
        fr_shift    = 32'd0;
        fr_type     = 8'h00;
        fr_plen     = 16'd0;
        fr_addr     = 32'd0;
        fr_rlen     = 32'd0;
        fr_idle     = 16'd0;
        cfg_timeout = msd_pkg::TIMEOUT_RESET;
        cfg_bufsize = msd_pkg::BUFSIZE_RESET;

        // Directed table: {cmd, byte, typed, results, final event, packet type}
        // empty device-info request completes on the last header byte
        directed_rows[0]  = {msd_pkg::CMD_BYTE, 8'hDE, 1'b0, 2'd0, msd_pkg::EV_OK, 8'h00};
        directed_rows[1]  = {msd_pkg::CMD_BYTE, 8'hAD, 1'b0, 2'd0, msd_pkg::EV_OK, 8'h00};
        directed_rows[2]  = {msd_pkg::CMD_BYTE, 8'hBE, 1'b0, 2'd0, msd_pkg::EV_OK, 8'h00};
        directed_rows[3]  = {msd_pkg::CMD_BYTE, 8'hEF, 1'b0, 2'd0, msd_pkg::EV_OK, 8'h00};
        directed_rows[4]  = {msd_pkg::CMD_BYTE, msd_pkg::TYPE_DEVINFO, 1'b0, 2'd0,
                             msd_pkg::EV_OK, 8'h00};
        directed_rows[5]  = {msd_pkg::CMD_BYTE, 8'h00, 1'b0, 2'd0, msd_pkg::EV_OK, 8'h00};
        directed_rows[6]  = {msd_pkg::CMD_BYTE, 8'h00, 1'b1, 2'd2, msd_pkg::EV_DEVINFO,
                             msd_pkg::TYPE_DEVINFO};
        // all-ones type and length: length above the buffer
        directed_rows[7]  = {msd_pkg::CMD_BYTE, 8'hDE, 1'b0, 2'd0, msd_pkg::EV_OK, 8'h00};
        directed_rows[8]  = {msd_pkg::CMD_BYTE, 8'hAD, 1'b0, 2'd0, msd_pkg::EV_OK, 8'h00};
        directed_rows[9]  = {msd_pkg::CMD_BYTE, 8'hBE, 1'b0, 2'd0, msd_pkg::EV_OK, 8'h00};
        directed_rows[10] = {msd_pkg::CMD_BYTE, 8'hEF, 1'b0, 2'd0, msd_pkg::EV_OK, 8'h00};
        directed_rows[11] = {msd_pkg::CMD_BYTE, 8'hFF, 1'b0, 2'd0, msd_pkg::EV_OK, 8'h00};
        directed_rows[12] = {msd_pkg::CMD_BYTE, 8'hFF, 1'b0, 2'd0, msd_pkg::EV_OK, 8'h00};
        directed_rows[13] = {msd_pkg::CMD_BYTE, 8'hFF, 1'b1, 2'd1, msd_pkg::EV_BAD_LEN, 8'hFF};
        // a block of zeros is not the sync word: dropped silently
        directed_rows[14] = {msd_pkg::CMD_BYTE, 8'h00, 1'b1, 2'd0, msd_pkg::EV_OK, 8'h00};
        directed_rows[15] = {msd_pkg::CMD_BYTE, 8'h00, 1'b1, 2'd0, msd_pkg::EV_OK, 8'h00};
        directed_rows[16] = {msd_pkg::CMD_BYTE, 8'h00, 1'b1, 2'd0, msd_pkg::EV_OK, 8'h00};
        directed_rows[17] = {msd_pkg::CMD_BYTE, 8'h00, 1'b1, 2'd0, msd_pkg::EV_OK, 8'h00};
        // empty packet of an unknown type
        directed_rows[18] = {msd_pkg::CMD_BYTE, 8'hDE, 1'b0, 2'd0, msd_pkg::EV_OK, 8'h00};
        directed_rows[19] = {msd_pkg::CMD_BYTE, 8'hAD, 1'b0, 2'd0, msd_pkg::EV_OK, 8'h00};
        directed_rows[20] = {msd_pkg::CMD_BYTE, 8'hBE, 1'b0, 2'd0, msd_pkg::EV_OK, 8'h00};
        directed_rows[21] = {msd_pkg::CMD_BYTE, 8'hEF, 1'b0, 2'd0, msd_pkg::EV_OK, 8'h00};
        directed_rows[22] = {msd_pkg::CMD_BYTE, 8'h80, 1'b0, 2'd0, msd_pkg::EV_OK, 8'h00};
        directed_rows[23] = {msd_pkg::CMD_BYTE, 8'h00, 1'b0, 2'd0, msd_pkg::EV_OK, 8'h00};
        directed_rows[24] = {msd_pkg::CMD_BYTE, 8'h00, 1'b1, 2'd2, msd_pkg::EV_UNKNOWN, 8'h80};
        // a lone tick: no result
        directed_rows[25] = {msd_pkg::CMD_TICK, 8'hFF, 1'b1, 2'd0, msd_pkg::EV_OK, 8'h00};

        // Hold reset, then release it on a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_request(directed_rows[i].cmd, directed_rows[i].b, directed_rows[i].typed,
                         directed_rows[i].nres, directed_rows[i].ev, directed_rows[i].ptype);
        drain_and_settle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // Program both registers while the block is idle
            cfg_we    <= 1'b1;
            cfg_index <= msd_pkg::CFG_TIMEOUT;
            cfg_wdata <= phase_timeout[ph];
            @(negedge aclk);
            cfg_index <= msd_pkg::CFG_BUFSIZE;
            cfg_wdata <= phase_bufsize[ph];
            @(negedge aclk);
            cfg_we <= 1'b0;
            cfg_timeout = phase_timeout[ph];
            cfg_bufsize = phase_bufsize[ph];
            @(negedge aclk);

            if (ph == PRESSURE_PHASE)
                hold_request = 1'b1;
            begin
                int goal;
                goal = items_sent + phase_items[ph];
                while (items_sent < goal) begin
                    if ($urandom_range(0, 9) < 7)
                        random_frame();
                    else
                        line_noise();
                end
            end
            drain_and_settle();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
